// File: design/pag_pkg.sv
// ----------------------------------------------------------------------------
// pag_pkg
// Shared constants, accumulator type and saturating add for the polygon
// area and bounds core.
// ----------------------------------------------------------------------------
package pag_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ACC_BITS       = 50;

    typedef logic signed [ACC_BITS-1:0] acc_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    // a + b, clamped to the accumulator range
    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        logic signed [ACC_BITS:0] s;
        s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
        if (s[ACC_BITS] != s[ACC_BITS-1]) begin
            return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_BITS-1:0];
    endfunction

endpackage

// File: design/polygon_area_and_bounds_core.sv
// ----------------------------------------------------------------------------
// polygon_area_and_bounds_core
// Streams polygon vertices and returns twice the signed shoelace area plus
// the bounding box for each polygon closed by tlast.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  s_      | in        | one vertex per request, tlast on the last vertex
//  m_      | out       | one result per polygon
//
//  Takes one vertex every cycle unless a stalled result holds it back;
//  three register stages (tracking, multiply, result) lie between the last
//  vertex of a polygon and its result.
//  The accumulator clears as it loads a result, so there is no gap between
//  polygons. Reset (aresetn low, synchronous) drops any open polygon.
//  A stalled result holds back only a closing vertex and the ones behind it.
// ----------------------------------------------------------------------------
module polygon_area_and_bounds_core #(
    parameter int COORD_BITS = pag_pkg::COORD_BITS_DEF
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // vertex_x, vertex_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]                     s_tdata,
    input  logic                                                  s_tlast,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // twice_area, box_min_x, box_min_y, box_max_x, box_max_y, box_width, box_height
    output logic [((pag_pkg::ACC_BITS+6*COORD_BITS+7)/8)*8-1:0]   m_tdata
);
    import pag_pkg::*;

    localparam int SW  = COORD_BITS + 1;
    localparam int PW  = 2 * SW;
    localparam int EW  = (PW > ACC_BITS) ? PW : ACC_BITS;
    localparam int MW  = ((ACC_BITS + 6*COORD_BITS + 7) / 8) * 8;
    localparam int MPD = MW - ACC_BITS - 6*COORD_BITS;

    logic signed [COORD_BITS-1:0] vx, vy;

    logic                         f_valid, f_ready, f_fin;
    logic signed [SW-1:0]         f_sx1, f_dy1, f_sx2, f_dy2;
    logic signed [COORD_BITS-1:0] f_lo_x, f_lo_y, f_hi_x, f_hi_y;

    logic signed [PW-1:0]         prod1, prod2;
    logic                         mv_reg, mfin_reg;
    acc_t                         t1_reg, t2_reg;
    logic signed [COORD_BITS-1:0] mlo_x_reg, mlo_y_reg, mhi_x_reg, mhi_y_reg;
    logic                         a_ready;

    acc_t                  r_area;
    logic [COORD_BITS-1:0] r_lo_x, r_lo_y, r_hi_x, r_hi_y, r_w, r_h;

    // clamp a product to the accumulator range
    function automatic acc_t clamp_term(input logic signed [EW-1:0] v);
        logic upper_ones, upper_zeros;
        upper_ones  = &v[EW-1:ACC_BITS-1];
        upper_zeros = ~|v[EW-1:ACC_BITS-1];
        if (upper_ones || upper_zeros) begin
            return v[ACC_BITS-1:0];
        end
        return v[EW-1] ? ACC_MIN : ACC_MAX;
    endfunction

    assign vx = s_tdata[COORD_BITS-1:0];
    assign vy = s_tdata[2*COORD_BITS-1:COORD_BITS];

    pag_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_x     (vx),
        .in_y     (vy),
        .in_fin   (s_tlast),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_fin  (f_fin),
        .out_sx1  (f_sx1),
        .out_dy1  (f_dy1),
        .out_sx2  (f_sx2),
        .out_dy2  (f_dy2),
        .out_lo_x (f_lo_x),
        .out_lo_y (f_lo_y),
        .out_hi_x (f_hi_x),
        .out_hi_y (f_hi_y)
    );

    // multiply stage
    assign prod1   = PW'(f_sx1) * PW'(f_dy1);
    assign prod2   = PW'(f_sx2) * PW'(f_dy2);
    assign f_ready = !mv_reg || a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (f_ready) begin
            mv_reg <= f_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_ready && f_valid) begin
            mfin_reg  <= f_fin;
            t1_reg    <= clamp_term(EW'(prod1));
            t2_reg    <= clamp_term(EW'(prod2));
            mlo_x_reg <= f_lo_x;
            mlo_y_reg <= f_lo_y;
            mhi_x_reg <= f_hi_x;
            mhi_y_reg <= f_hi_y;
        end
    end

    pag_accum #(.COORD_BITS(COORD_BITS)) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mv_reg),
        .in_ready  (a_ready),
        .in_fin    (mfin_reg),
        .in_t1     (t1_reg),
        .in_t2     (t2_reg),
        .in_lo_x   (mlo_x_reg),
        .in_lo_y   (mlo_y_reg),
        .in_hi_x   (mhi_x_reg),
        .in_hi_y   (mhi_y_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_area  (r_area),
        .out_lo_x  (r_lo_x),
        .out_lo_y  (r_lo_y),
        .out_hi_x  (r_hi_x),
        .out_hi_y  (r_hi_y),
        .out_width (r_w),
        .out_height(r_h)
    );

    generate
        if (MPD > 0) begin : g_pad
            assign m_tdata = {{MPD{1'b0}}, r_h, r_w, r_hi_y, r_hi_x, r_lo_y, r_lo_x, r_area};
        end else begin : g_nopad
            assign m_tdata = {r_h, r_w, r_hi_y, r_hi_x, r_lo_y, r_lo_x, r_area};
        end
    endgenerate

endmodule

// File: design/pag_front.sv
// ----------------------------------------------------------------------------
// pag_front
// Vertex tracking: first and previous vertex, bounding box, and the edge
// operands (sum of x, difference of y) for the running and closing terms.
// ----------------------------------------------------------------------------
module pag_front #(
    parameter int COORD_BITS = pag_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic                         in_fin,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_fin,
    output logic signed [COORD_BITS:0]   out_sx1,
    output logic signed [COORD_BITS:0]   out_dy1,
    output logic signed [COORD_BITS:0]   out_sx2,
    output logic signed [COORD_BITS:0]   out_dy2,
    output logic signed [COORD_BITS-1:0] out_lo_x,
    output logic signed [COORD_BITS-1:0] out_lo_y,
    output logic signed [COORD_BITS-1:0] out_hi_x,
    output logic signed [COORD_BITS-1:0] out_hi_y
);
    import pag_pkg::*;

    localparam int SW = COORD_BITS + 1;

    logic                         started_reg, started_next;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] lo_x_reg, lo_y_reg, hi_x_reg, hi_y_reg;
    logic signed [COORD_BITS-1:0] lo_x_next, lo_y_next, hi_x_next, hi_y_next;
    logic signed [COORD_BITS-1:0] first_x_eff, first_y_eff;
    logic signed [SW-1:0]         sx1_next, dy1_next, sx2_next, dy2_next;

    logic                         v_reg;
    logic                         fin_reg;
    logic signed [SW-1:0]         sx1_reg, dy1_reg, sx2_reg, dy2_reg;
    logic signed [COORD_BITS-1:0] bl_x_reg, bl_y_reg, bh_x_reg, bh_y_reg;

    logic accept;

    assign in_ready = !v_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        first_x_eff = started_reg ? first_x_reg : in_x;
        first_y_eff = started_reg ? first_y_reg : in_y;
        if (started_reg) begin
            lo_x_next = (in_x < lo_x_reg) ? in_x : lo_x_reg;
            hi_x_next = (in_x > hi_x_reg) ? in_x : hi_x_reg;
            lo_y_next = (in_y < lo_y_reg) ? in_y : lo_y_reg;
            hi_y_next = (in_y > hi_y_reg) ? in_y : hi_y_reg;
            sx1_next  = SW'(prev_x_reg) + SW'(in_x);
            dy1_next  = SW'(prev_y_reg) - SW'(in_y);
        end else begin
            lo_x_next = in_x;
            hi_x_next = in_x;
            lo_y_next = in_y;
            hi_y_next = in_y;
            sx1_next  = '0;
            dy1_next  = '0;
        end
        // closing edge back to the first vertex, only on the last one
        if (in_fin) begin
            sx2_next = SW'(in_x) + SW'(first_x_eff);
            dy2_next = SW'(in_y) - SW'(first_y_eff);
        end else begin
            sx2_next = '0;
            dy2_next = '0;
        end
        started_next = !in_fin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            v_reg       <= 1'b0;
        end else begin
            if (accept) begin
                started_reg <= started_next;
            end
            if (in_ready) begin
                v_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            first_x_reg <= first_x_eff;
            first_y_reg <= first_y_eff;
            prev_x_reg  <= in_x;
            prev_y_reg  <= in_y;
            lo_x_reg    <= lo_x_next;
            lo_y_reg    <= lo_y_next;
            hi_x_reg    <= hi_x_next;
            hi_y_reg    <= hi_y_next;
            fin_reg     <= in_fin;
            sx1_reg     <= sx1_next;
            dy1_reg     <= dy1_next;
            sx2_reg     <= sx2_next;
            dy2_reg     <= dy2_next;
            bl_x_reg    <= lo_x_next;
            bl_y_reg    <= lo_y_next;
            bh_x_reg    <= hi_x_next;
            bh_y_reg    <= hi_y_next;
        end
    end

    assign out_valid = v_reg;
    assign out_fin   = fin_reg;
    assign out_sx1   = sx1_reg;
    assign out_dy1   = dy1_reg;
    assign out_sx2   = sx2_reg;
    assign out_dy2   = dy2_reg;
    assign out_lo_x  = bl_x_reg;
    assign out_lo_y  = bl_y_reg;
    assign out_hi_x  = bh_x_reg;
    assign out_hi_y  = bh_y_reg;

endmodule

// File: design/pag_accum.sv
// ----------------------------------------------------------------------------
// pag_accum
// Saturating shoelace accumulator and result register. Running and closing
// terms are added in order; the last vertex loads the result and clears.
// ----------------------------------------------------------------------------
module pag_accum #(
    parameter int COORD_BITS = pag_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_fin,
    input  pag_pkg::acc_t                in_t1,
    input  pag_pkg::acc_t                in_t2,
    input  logic signed [COORD_BITS-1:0] in_lo_x,
    input  logic signed [COORD_BITS-1:0] in_lo_y,
    input  logic signed [COORD_BITS-1:0] in_hi_x,
    input  logic signed [COORD_BITS-1:0] in_hi_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pag_pkg::acc_t                out_area,
    output logic [COORD_BITS-1:0]        out_lo_x,
    output logic [COORD_BITS-1:0]        out_lo_y,
    output logic [COORD_BITS-1:0]        out_hi_x,
    output logic [COORD_BITS-1:0]        out_hi_y,
    output logic [COORD_BITS-1:0]        out_width,
    output logic [COORD_BITS-1:0]        out_height
);
    import pag_pkg::*;

    acc_t acc_reg;
    acc_t sum1, sum2;
    logic valid_reg;
    logic accept, load;

    acc_t                  area_reg;
    logic [COORD_BITS-1:0] lo_x_reg, lo_y_reg, hi_x_reg, hi_y_reg;
    logic [COORD_BITS-1:0] width_reg, height_reg;

    // vertices that do not close a polygon never wait on the result side
    assign in_ready = !in_fin || !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign load     = accept && in_fin;

    assign sum1 = sat_add(acc_reg, in_t1);
    assign sum2 = sat_add(sum1, in_t2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                acc_reg <= in_fin ? '0 : sum1;
            end
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            area_reg   <= sum2;
            lo_x_reg   <= in_lo_x;
            lo_y_reg   <= in_lo_y;
            hi_x_reg   <= in_hi_x;
            hi_y_reg   <= in_hi_y;
            width_reg  <= COORD_BITS'(in_hi_x - in_lo_x);
            height_reg <= COORD_BITS'(in_hi_y - in_lo_y);
        end
    end

    assign out_valid  = valid_reg;
    assign out_area   = area_reg;
    assign out_lo_x   = lo_x_reg;
    assign out_lo_y   = lo_y_reg;
    assign out_hi_x   = hi_x_reg;
    assign out_hi_y   = hi_y_reg;
    assign out_width  = width_reg;
    assign out_height = height_reg;

endmodule

// File: design/pag_checker.sv
// ----------------------------------------------------------------------------
// pag_checker
// Port-level checks on the polygon area and bounds core results.
// ----------------------------------------------------------------------------
module pag_checker #(
    parameter int COORD_BITS = pag_pkg::COORD_BITS_DEF
) (
    input logic                                                aclk,
    input logic                                                aresetn,
    input logic                                                m_tvalid,
    input logic                                                m_tready,
    input logic [((pag_pkg::ACC_BITS+6*COORD_BITS+7)/8)*8-1:0] m_tdata
);
    import pag_pkg::*;

    localparam int B0 = ACC_BITS;

    logic signed [COORD_BITS-1:0] min_x, min_y, max_x, max_y;
    logic [COORD_BITS-1:0]        box_w, box_h;

    assign min_x = m_tdata[B0+COORD_BITS-1:B0];
    assign min_y = m_tdata[B0+2*COORD_BITS-1:B0+COORD_BITS];
    assign max_x = m_tdata[B0+3*COORD_BITS-1:B0+2*COORD_BITS];
    assign max_y = m_tdata[B0+4*COORD_BITS-1:B0+3*COORD_BITS];
    assign box_w = m_tdata[B0+5*COORD_BITS-1:B0+4*COORD_BITS];
    assign box_h = m_tdata[B0+6*COORD_BITS-1:B0+5*COORD_BITS];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_box_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (min_x <= max_x) && (min_y <= max_y))
        else $error("box corners out of order");

    a_box_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (box_w == COORD_BITS'(max_x - min_x))
                  && (box_h == COORD_BITS'(max_y - min_y)))
        else $error("box size does not match corners");

endmodule

bind polygon_area_and_bounds_core pag_checker #(.COORD_BITS(COORD_BITS)) u_pag_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for polygon_area_and_bounds_core. Vertices are streamed
// in bursts and a local shoelace/bounding-box predictor queues the summary of
// each closed polygon. Every returned summary is compared field by field.
// The run covers corner and degenerate polygons, long full-range windings in
// both directions, and random polygons under several output stall patterns.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW          = pag_pkg::COORD_BITS_DEF;
    localparam int AW          = pag_pkg::ACC_BITS;
    localparam int S_W         = ((2*CW+7)/8)*8;
    localparam int M_W         = ((AW+6*CW+7)/8)*8;
    localparam longint AREA_MAX = (longint'(1) <<< (AW-1)) - 1;
    localparam longint AREA_MIN = -AREA_MAX - 1;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int WIND_LOOPS  = 20;
    localparam int MAX_PRINTS  = 100;

    // result field offsets in m_tdata
    localparam int MINX_LSB = AW;
    localparam int MINY_LSB = AW + CW;
    localparam int MAXX_LSB = AW + 2*CW;
    localparam int MAXY_LSB = AW + 3*CW;
    localparam int WID_LSB  = AW + 4*CW;
    localparam int HGT_LSB  = AW + 5*CW;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct {
        logic signed [AW-1:0] twice_area;
        coord_t               min_x;
        coord_t               min_y;
        coord_t               max_x;
        coord_t               max_y;
        logic [CW-1:0]        width;
        logic [CW-1:0]        height;
    } poly_summary_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PULSED, RX_BLOCKS} rx_mode_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;   // vertex_x, vertex_y
    logic           s_tlast  = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // twice_area, box_min_x, box_min_y, box_max_x, box_max_y, box_width, box_height
    logic [M_W-1:0] m_tdata;

    polygon_area_and_bounds_core #(
        .COORD_BITS(CW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #6 aclk = ~aclk;

    // predictor state
    bit     poly_open;
    int     first_x, first_y, prev_x, prev_y;
    int     lo_x, lo_y, hi_x, hi_y;
    longint area_acc;

    poly_summary_t pending_polygons[$];

    int       mismatch_count  = 0;
    int       results_checked = 0;
    int       vertices_sent   = 0;
    int       polygons_closed = 0;
    int       cycle_count     = 0;
    int       burst_left      = 0;
    bit       pace_on         = 1'b1;
    rx_mode_t rx_mode         = RX_ALWAYS;
    logic [7:0] rx_tick       = '0;

    function automatic longint clamp_area(input longint v);
        if (v > AREA_MAX) return AREA_MAX;
        if (v < AREA_MIN) return AREA_MIN;
        return v;
    endfunction

    // (ax + bx) * (ay - by), clamped to the accumulator range
    function automatic longint shoelace_term(input int ax, input int ay,
                                             input int bx, input int by);
        return clamp_area(longint'(ax + bx) * longint'(ay - by));
    endfunction

    function automatic void track_vertex(input coord_t vx, input coord_t vy,
                                         input bit closes);
        int            x;
        int            y;
        int            span_x;
        int            span_y;
        poly_summary_t s;
        x = vx;
        y = vy;
        if (!poly_open) begin
            poly_open = 1'b1;
            first_x   = x;
            first_y   = y;
            lo_x      = x;
            hi_x      = x;
            lo_y      = y;
            hi_y      = y;
            area_acc  = 0;
        end else begin
            area_acc = clamp_area(area_acc + shoelace_term(prev_x, prev_y, x, y));
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
        end
        prev_x = x;
        prev_y = y;
        if (closes) begin
            // closing edge back to the first vertex
            area_acc = clamp_area(area_acc + shoelace_term(x, y, first_x, first_y));
            span_x = hi_x - lo_x;
            span_y = hi_y - lo_y;
            s.twice_area = area_acc[AW-1:0];
            s.min_x      = lo_x[CW-1:0];
            s.min_y      = lo_y[CW-1:0];
            s.max_x      = hi_x[CW-1:0];
            s.max_y      = hi_y[CW-1:0];
            s.width      = span_x[CW-1:0];
            s.height     = span_y[CW-1:0];
            pending_polygons = {pending_polygons, s};
            polygons_closed++;
            poly_open = 1'b0;
            first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
            lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
            area_acc = 0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0d] mismatch on %s: got %h, want %h (result %0d)",
                     cycle_count, what, got, want, results_checked);
        mismatch_count++;
    endtask

    // one vertex request; called at a rising edge, returns at the accepting edge
    task automatic send_vertex(input coord_t x, input coord_t y, input bit closes);
        int gap;
        if (burst_left == 0) begin
            gap        = pace_on ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= closes;
        do @(posedge aclk); while (!s_tready);
        vertices_sent++;
        track_vertex(x, y, closes);
    endtask

    function automatic coord_t pick_coord(input int style);
        int r;
        if ($urandom_range(0, 9) == 0) style = 1;
        case (style)
            1: begin
                case ($urandom_range(0, 6))
                    0:       return C_MIN;
                    1:       return C_MIN + coord_t'(1);
                    2:       return coord_t'(-1);
                    3:       return coord_t'(0);
                    4:       return coord_t'(1);
                    5:       return C_MAX - coord_t'(1);
                    default: return C_MAX;
                endcase
            end
            2: begin
                r = $urandom_range(0, 256);
                return coord_t'(r - 128);
            end
            3: begin
                r = $urandom_range(0, 63);
                return ($urandom_range(0, 1) != 0) ? C_MAX - coord_t'(r) : C_MIN + coord_t'(r);
            end
            default: return coord_t'($urandom);
        endcase
    endfunction

    // output stall pattern
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1'b1;
        case (rx_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            RX_PULSED: m_tready <= (rx_tick[2:0] == 3'd3);
            default:   m_tready <= (rx_tick[6:5] != 2'b11);
        endcase
    end

    always @(posedge aclk) begin : check_results
        poly_summary_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_polygons.size() == 0) begin
                report_mismatch("result with no polygon outstanding", m_tdata[63:0], '0);
            end else begin
                want = pending_polygons.pop_front();
                if (m_tdata[0 +: AW] !== want.twice_area)
                    report_mismatch("twice_area", m_tdata[0 +: AW], want.twice_area);
                if (m_tdata[MINX_LSB +: CW] !== want.min_x)
                    report_mismatch("box_min_x", m_tdata[MINX_LSB +: CW], want.min_x);
                if (m_tdata[MINY_LSB +: CW] !== want.min_y)
                    report_mismatch("box_min_y", m_tdata[MINY_LSB +: CW], want.min_y);
                if (m_tdata[MAXX_LSB +: CW] !== want.max_x)
                    report_mismatch("box_max_x", m_tdata[MAXX_LSB +: CW], want.max_x);
                if (m_tdata[MAXY_LSB +: CW] !== want.max_y)
                    report_mismatch("box_max_y", m_tdata[MAXY_LSB +: CW], want.max_y);
                if (m_tdata[WID_LSB +: CW] !== want.width)
                    report_mismatch("box_width", m_tdata[WID_LSB +: CW], want.width);
                if (m_tdata[HGT_LSB +: CW] !== want.height)
                    report_mismatch("box_height", m_tdata[HGT_LSB +: CW], want.height);
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_polygons.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_single_vertex();
        rx_mode = RX_RANDOM;
        pace_on = 1'b1;
        send_vertex(C_MIN, C_MAX, 1'b1);
        send_vertex(0, 0, 1'b1);
        send_vertex(C_MAX, C_MIN, 1'b1);
        send_vertex(-1, -1, 1'b1);
    endtask

    task automatic test_box_corners();
        rx_mode = RX_PULSED;
        // full-range square, both windings
        send_vertex(C_MAX, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MIN, 1'b1);
        send_vertex(C_MAX, C_MAX, 1'b0);
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);
        send_vertex(0, 0, 1'b0);
        send_vertex(C_MAX, 0, 1'b0);
        send_vertex(0, C_MAX, 1'b1);
    endtask

    task automatic test_degenerate();
        rx_mode = RX_RANDOM;
        // a segment and a triangle with a repeated vertex: both have zero area
        send_vertex(5, -7, 1'b0);
        send_vertex(-3, 9, 1'b1);
        send_vertex(100, 100, 1'b0);
        send_vertex(100, 100, 1'b0);
        send_vertex(-50, 20, 1'b1);
    endtask

    // wind around the full box many times, each direction, to grow the sum wide
    task automatic test_large_winding();
        rx_mode = RX_ALWAYS;
        pace_on = 1'b0;
        for (int k = 0; k < WIND_LOOPS; k++) begin
            send_vertex(C_MAX, C_MAX, 1'b0);
            send_vertex(C_MIN, C_MAX, 1'b0);
            send_vertex(C_MIN, C_MIN, 1'b0);
            send_vertex(C_MAX, C_MIN, 1'b0);
        end
        // one loop back the other way takes part of the sum off again
        send_vertex(C_MAX, C_MAX, 1'b0);
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);
        for (int k = 0; k < WIND_LOOPS; k++) begin
            send_vertex(C_MAX, C_MAX, 1'b0);
            send_vertex(C_MAX, C_MIN, 1'b0);
            send_vertex(C_MIN, C_MIN, 1'b0);
            send_vertex(C_MIN, C_MAX, k == WIND_LOOPS - 1);
        end
    endtask

    task automatic test_random_polygons(input int vertex_budget);
        int     sent;
        int     n;
        int     style;
        coord_t x;
        coord_t y;
        sent = 0;
        while (sent < vertex_budget) begin
            case (sent * 4 / vertex_budget)
                0:       begin rx_mode = RX_RANDOM; pace_on = 1'b1; end
                1:       begin rx_mode = RX_ALWAYS; pace_on = 1'b0; end
                2:       begin rx_mode = RX_PULSED; pace_on = 1'b1; end
                default: begin rx_mode = RX_BLOCKS; pace_on = 1'b1; end
            endcase
            n     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            style = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                x = pick_coord(style);
                y = pick_coord(style);
                send_vertex(x, y, i == n - 1);
            end
            sent += n;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_single_vertex();
        test_box_corners();
        test_degenerate();
        test_large_winding();
        test_random_polygons(1200);
        s_tvalid <= 1'b0;
        while (pending_polygons.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("%0d vertices in %0d polygons, %0d summaries checked, %0d mismatches",
                 vertices_sent, polygons_closed, results_checked, mismatch_count);
        $display("included point polygons, full-range boxes and long windings both ways");
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: polygon_area_and_bounds_core.f
design/pag_pkg.sv
design/pag_front.sv
design/pag_accum.sv
design/polygon_area_and_bounds_core.sv
design/pag_checker.sv
test/tb.sv
